>>> design/dsu_pkg.sv
// Shared types and constants of the disjoint-set union/find engine.
// No dependencies; imported by dsu_wrap, the top module and the testbench.
`default_nettype none

package dsu_pkg;

    // fixed widths of the item fields and the answer, and the default element count
    localparam int FIELD_W      = 12;
    localparam int OP_W         = 2;
    localparam int ANS_W        = 2;
    localparam int DEF_ELEMENTS = 4096;

    // operation codes
    localparam logic [OP_W-1:0] OP_UNION = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;

    // answer codes
    localparam logic [ANS_W-1:0] ANS_DIFF    = 2'd0;
    localparam logic [ANS_W-1:0] ANS_SAME    = 2'd1;
    localparam logic [ANS_W-1:0] ANS_INVALID = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WRAP,
        S_PREP,
        S_RD,
        S_ROOT,
        S_COMP,
        S_LINK
    } t_state;

endpackage : dsu_pkg

`default_nettype wire

>>> design/dsu_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module dsu_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule : dsu_ram

`default_nettype wire

>>> design/dsu_wrap.sv
// Iterative reduction of both element fields modulo ELEMENTS, one
// compare-and-subtract step per cycle. Depends on dsu_pkg.
`default_nettype none

module dsu_wrap
    import dsu_pkg::*;
#(
    parameter int ELEMENTS = DEF_ELEMENTS,
    parameter int IDX_W    = $clog2(DEF_ELEMENTS)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [FIELD_W-1:0] i_a,
    input  wire logic [FIELD_W-1:0] i_b,
    output logic                    o_done,
    output logic      [IDX_W-1:0]   o_a,
    output logic      [IDX_W-1:0]   o_b
);

    localparam int FIELD_SPAN = 2 ** FIELD_W;
    // steps so that ELEMENTS << steps exceeds any field value
    localparam int WRAP_STEPS = (ELEMENTS >= FIELD_SPAN) ? 0 :
                                $clog2((FIELD_SPAN + ELEMENTS - 1) / ELEMENTS);
    localparam int CNT_W      = (WRAP_STEPS < 1) ? 1 : $clog2(WRAP_STEPS + 1);
    localparam logic [FIELD_W:0] ELEM_N = (FIELD_W + 1)'(ELEMENTS);

    logic [FIELD_W-1:0] r_a, r_b;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic [FIELD_W:0]   step;

    assign step = ELEM_N << (r_cnt - CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(WRAP_STEPS);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end else if (r_busy && r_cnt != '0) begin
            if ({1'b0, r_a} >= step) begin
                r_a <= FIELD_W'({1'b0, r_a} - step);
            end
            if ({1'b0, r_b} >= step) begin
                r_b <= FIELD_W'({1'b0, r_b} - step);
            end
        end
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_a    = IDX_W'(r_a);
    assign o_b    = IDX_W'(r_b);

endmodule : dsu_wrap

`default_nettype wire

>>> design/disjoint_set_union_find_top.sv
// Channel  | Ports                                    | Handshake
// ---------+------------------------------------------+---------------------------
// command  | i_operation, i_elem_a, i_elem_b          | taken when start & !busy
// result   | o_answer                                 | o_answer_valid, one cycle
//
// An invalid operation answers in the cycle after it is taken. Any other item
// has its indices reduced modulo ELEMENTS by dsu_wrap. A query of two equal
// indices then answers from S_PREP; otherwise each index gets a find that walks
// the pointers to the root and points the walked nodes at it; S_LINK links or
// answers. The single parent-table read port sets the pace. After reset the
// parent table is swept, one entry a cycle, busy high. Results cannot be stalled.
// Depends on dsu_pkg, dsu_ram, dsu_wrap.
`default_nettype none

module disjoint_set_union_find_top
    import dsu_pkg::*;
#(
    parameter int ELEMENTS = DEF_ELEMENTS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [OP_W-1:0]    i_operation,
    input  wire logic [FIELD_W-1:0] i_elem_a,
    input  wire logic [FIELD_W-1:0] i_elem_b,
    output logic                    o_answer_valid,
    output logic      [ANS_W-1:0]   o_answer
);

    localparam int IDX_W = $clog2(ELEMENTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ELEMENTS - 1);

    t_state            r_state, n_state;
    logic [OP_W-1:0]   r_op, n_op;
    logic [IDX_W-1:0]  r_a, n_a, r_b, n_b;
    logic [IDX_W-1:0]  r_cur, n_cur;
    logic [IDX_W-1:0]  r_root, n_root;
    logic [IDX_W-1:0]  r_ra, n_ra;
    logic [IDX_W-1:0]  r_clr, n_clr;
    logic              r_sel, n_sel;
    logic              r_dir, n_dir;
    logic              r_valid, n_valid;
    logic [ANS_W-1:0]  r_answer, n_answer;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr, ram_wdata, ram_raddr, ram_rdata;

    logic              accept, op_ok, wrap_go, wrap_done;
    logic [IDX_W-1:0]  wrap_a, wrap_b, start_node;
    logic              root_hit, comp_end;

    assign busy       = (r_state != S_IDLE);
    assign accept     = start && !busy;
    assign op_ok      = (i_operation == OP_UNION) || (i_operation == OP_QUERY);
    assign wrap_go    = accept && op_ok;
    assign start_node = r_sel ? r_b : r_a;
    assign root_hit   = (ram_rdata == r_cur);
    assign comp_end   = (ram_rdata == r_root);

    dsu_ram #(
        .WIDTH (IDX_W),
        .DEPTH (ELEMENTS)
    ) u_parent (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    dsu_wrap #(
        .ELEMENTS (ELEMENTS),
        .IDX_W    (IDX_W)
    ) u_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (wrap_go),
        .i_a     (i_elem_a),
        .i_b     (i_elem_b),
        .o_done  (wrap_done),
        .o_a     (wrap_a),
        .o_b     (wrap_b)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == LAST_IDX) n_state = S_IDLE;
            S_IDLE:  if (wrap_go) n_state = S_WRAP;
            S_WRAP:  if (wrap_done) n_state = S_PREP;
            S_PREP: begin
                if (r_op == OP_QUERY && r_a == r_b) n_state = S_IDLE;
                else                                n_state = S_RD;
            end
            S_RD:    n_state = S_ROOT;
            S_ROOT: begin
                if (root_hit) begin
                    if (start_node == r_cur) n_state = r_sel ? S_LINK : S_RD;
                    else                     n_state = S_COMP;
                end
            end
            S_COMP:  if (comp_end) n_state = r_sel ? S_LINK : S_RD;
            S_LINK:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and parent-table port
    always_comb begin
        n_op      = r_op;
        n_a       = r_a;
        n_b       = r_b;
        n_cur     = r_cur;
        n_root    = r_root;
        n_ra      = r_ra;
        n_clr     = r_clr;
        n_sel     = r_sel;
        n_dir     = r_dir;
        n_valid   = 1'b0;
        n_answer  = r_answer;
        ram_we    = 1'b0;
        ram_waddr = r_cur;
        ram_wdata = r_root;
        ram_raddr = r_cur;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = r_clr;
                n_clr     = r_clr + IDX_W'(1);
            end
            S_IDLE: begin
                if (accept) begin
                    n_op = i_operation;
                    if (!op_ok) begin
                        n_valid  = 1'b1;
                        n_answer = ANS_INVALID;
                    end
                end
            end
            S_WRAP: begin
                if (wrap_done) begin
                    n_a = wrap_a;
                    n_b = wrap_b;
                end
            end
            S_PREP: begin
                if (r_op == OP_QUERY && r_a == r_b) begin
                    n_valid  = 1'b1;
                    n_answer = ANS_SAME;
                end else begin
                    n_sel = 1'b0;
                    n_cur = r_a;
                end
            end
            S_RD: begin
                ram_raddr = r_cur;
            end
            S_ROOT: begin
                if (!root_hit) begin
                    n_cur     = ram_rdata;
                    ram_raddr = ram_rdata;
                end else begin
                    n_root = r_cur;
                    if (start_node == r_cur) begin
                        // start node is the root: no path to compress, find is over
                        if (!r_sel) begin
                            n_ra  = r_cur;
                            n_sel = 1'b1;
                            n_cur = r_b;
                        end
                    end else begin
                        n_cur     = start_node;
                        ram_raddr = start_node;
                    end
                end
            end
            S_COMP: begin
                // point the node at its root and step to its old parent
                ram_we    = 1'b1;
                ram_waddr = r_cur;
                ram_wdata = r_root;
                if (comp_end) begin
                    if (!r_sel) begin
                        n_ra  = r_root;
                        n_sel = 1'b1;
                        n_cur = r_b;
                    end
                end else begin
                    n_cur     = ram_rdata;
                    ram_raddr = ram_rdata;
                end
            end
            S_LINK: begin
                // r_root holds the second root here
                if (r_op == OP_UNION) begin
                    if (r_a != r_b && r_ra != r_root) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_dir ? r_ra : r_root;
                        ram_wdata = r_dir ? r_root : r_ra;
                        n_dir     = ~r_dir;
                    end
                end else begin
                    n_valid  = 1'b1;
                    n_answer = (r_ra == r_root) ? ANS_SAME : ANS_DIFF;
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_dir   <= 1'b1;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_dir   <= n_dir;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_a      <= n_a;
        r_b      <= n_b;
        r_cur    <= n_cur;
        r_root   <= n_root;
        r_ra     <= n_ra;
        r_sel    <= n_sel;
        r_answer <= n_answer;
    end

    assign o_answer_valid = r_valid;
    assign o_answer       = r_answer;

    // invalid operations answer at once
    a_invalid_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_operation != OP_UNION && i_operation != OP_QUERY
        |=> o_answer_valid && o_answer == ANS_INVALID)
        else $error("invalid operation not answered");

    // a continuing compression step never reads the entry it rewrites
    a_comp_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_COMP && !comp_end |-> ram_raddr != ram_waddr)
        else $error("read and write of one parent entry in the same cycle");

    // a union gives no result
    a_union_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LINK && r_op == OP_UNION |=> !o_answer_valid)
        else $error("union produced a result");

endmodule : disjoint_set_union_find_top

`default_nettype wire

>>> test/disjoint_set_union_find_top_test.sv
// Self-checking testbench for disjoint_set_union_find_top: unions, queries and
// invalid operations, each answer checked against an in-bench parent-table model.
// Depends on dsu_pkg and the RTL of the block only.
module disjoint_set_union_find_top_test
    import dsu_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ELEMENTS       = DEF_ELEMENTS;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int POOL_SIZE      = 40;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int TOP_INDEX      = (1 << FIELD_W) - 1;

    // codes outside the two valid operations
    localparam logic [OP_W-1:0] OP_BAD_2 = 2'd2;
    localparam logic [OP_W-1:0] OP_BAD_3 = 2'd3;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
        int                 idle_pct;
        bit                 drain_first;
    } cmd_item_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [OP_W-1:0]    i_operation = '0;
    logic [FIELD_W-1:0] i_elem_a = '0;
    logic [FIELD_W-1:0] i_elem_b = '0;
    logic               o_answer_valid;
    logic [ANS_W-1:0]   o_answer;

    cmd_item_t          pending_cmds[$];
    logic [ANS_W-1:0]   answers_due[$];
    int                 dsu_table[ELEMENTS];
    bit                 first_under_second;
    bit                 cmd_taken = 1'b0;
    int                 idle_cycles = 0;
    int                 fault_count = 0;
    int                 n_union = 0;
    int                 n_query = 0;
    int                 n_invalid = 0;
    int                 n_same = 0;
    int                 n_checked = 0;

    // settings applied to items as they are queued
    int                 phase_idle = 0;
    bit                 drain_next = 1'b0;
    logic [FIELD_W-1:0] elem_pool[POOL_SIZE];

    disjoint_set_union_find_top #(
        .ELEMENTS(ELEMENTS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_operation(i_operation),
        .i_elem_a(i_elem_a),
        .i_elem_b(i_elem_b),
        .o_answer_valid(o_answer_valid),
        .o_answer(o_answer)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // root search with full path compression on the walked nodes
    function automatic int root_of(int node);
        int root;
        int walk;
        int nxt;
        int steps;
        root = node;
        steps = 0;
        while (dsu_table[root] != root && steps < ELEMENTS) begin
            root = dsu_table[root];
            steps++;
        end
        walk = node;
        steps = 0;
        while (walk != root && steps < ELEMENTS) begin
            nxt = dsu_table[walk];
            dsu_table[walk] = root;
            walk = nxt;
            steps++;
        end
        return root;
    endfunction

    // applies one item to the table; returns 1 when it yields an answer
    function automatic bit apply_command(input logic [OP_W-1:0] op,
                                         input logic [FIELD_W-1:0] ea,
                                         input logic [FIELD_W-1:0] eb,
                                         output logic [ANS_W-1:0] ans);
        int xa;
        int xb;
        int ra;
        int rb;
        xa = int'(ea) % ELEMENTS;
        xb = int'(eb) % ELEMENTS;
        ans = ANS_INVALID;
        if (op == OP_UNION) begin
            ra = root_of(xa);
            rb = root_of(xb);
            if (xa != xb && ra != rb) begin
                if (first_under_second)
                    dsu_table[ra] = rb;
                else
                    dsu_table[rb] = ra;
                first_under_second = !first_under_second;
            end
            return 1'b0;
        end
        if (op == OP_QUERY) begin
            // equal elements answer at once, no walk and no compression
            if (xa == xb) begin
                ans = ANS_SAME;
            end else begin
                ra = root_of(xa);
                rb = root_of(xb);
                ans = (ra == rb) ? ANS_SAME : ANS_DIFF;
            end
        end
        return 1'b1;
    endfunction

    task automatic queue_cmd(input logic [OP_W-1:0] op, input int a, input int b);
        cmd_item_t c;
        c.op = op;
        c.a = FIELD_W'(a);
        c.b = FIELD_W'(b);
        c.idle_pct = phase_idle;
        c.drain_first = drain_next;
        drain_next = 1'b0;
        pending_cmds.push_back(c);
    endtask

    function automatic int pick_elem();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return int'(elem_pool[$urandom_range(0, POOL_SIZE - 1)]);
        if (r < 90)
            return $urandom_range(0, TOP_INDEX);
        if (r < 95)
            return $urandom_range(0, 3);
        return $urandom_range(TOP_INDEX - 3, TOP_INDEX);
    endfunction

    task automatic queue_random_phase(input int idle_pct);
        int r;
        logic [OP_W-1:0] op;
        phase_idle = idle_pct;
        drain_next = 1'b1;
        for (int i = 0; i < POOL_SIZE; i++)
            elem_pool[i] = FIELD_W'($urandom_range(0, TOP_INDEX));
        for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45)
                op = OP_UNION;
            else if (r < 87)
                op = OP_QUERY;
            else if (r < 94)
                op = OP_BAD_2;
            else
                op = OP_BAD_3;
            queue_cmd(op, pick_elem(), pick_elem());
        end
    endtask

    // driver: holds an item until it is taken, then moves to the next
    always @(negedge i_clk) begin : drive_commands
        cmd_item_t c;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && !cmd_taken)) begin
            if (pending_cmds.size() != 0
                    && (!pending_cmds[0].drain_first || (answers_due.size() == 0 && !busy))
                    && $urandom_range(0, 99) >= pending_cmds[0].idle_pct) begin
                c = pending_cmds.pop_front();
                i_operation <= c.op;
                i_elem_a <= c.a;
                i_elem_b <= c.b;
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: predicts on every accepted item and checks every answer strobe
    always @(posedge i_clk) begin : watch_results
        logic [ANS_W-1:0] ans;
        logic [ANS_W-1:0] want;
        bit accepted;
        accepted = i_rst_n && start && !busy;
        cmd_taken <= accepted;
        if (accepted) begin
            case (i_operation)
                OP_UNION: n_union++;
                OP_QUERY: n_query++;
                default:  n_invalid++;
            endcase
            if (apply_command(i_operation, i_elem_a, i_elem_b, ans))
                answers_due.push_back(ans);
        end
        if (i_rst_n && o_answer_valid) begin
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected answer, expected none, actual %0d", $time, o_answer);
                fault_count++;
            end else begin
                want = answers_due.pop_front();
                n_checked++;
                if (want == ANS_SAME)
                    n_same++;
                if (o_answer !== want) begin
                    $display("%0t: answer mismatch, expected %0d, actual %0d",
                             $time, want, o_answer);
                    fault_count++;
                end
            end
        end
        if (accepted || o_answer_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        for (int i = 0; i < ELEMENTS; i++)
            dsu_table[i] = i;
        first_under_second = 1'b1;

        // directed part
        phase_idle = 0;
        queue_cmd(OP_QUERY, 0, TOP_INDEX);          // different sets
        queue_cmd(OP_UNION, 0, TOP_INDEX);
        queue_cmd(OP_QUERY, TOP_INDEX, 0);          // same set
        queue_cmd(OP_QUERY, TOP_INDEX, TOP_INDEX);  // equal elements, no walk
        queue_cmd(OP_QUERY, 0, 0);
        queue_cmd(OP_UNION, 5, 5);                  // equal elements, no link
        queue_cmd(OP_UNION, TOP_INDEX, 0);          // equal roots, direction kept
        queue_cmd(OP_UNION, 10, 11);
        queue_cmd(OP_UNION, 11, 12);
        queue_cmd(OP_UNION, 12, 13);
        queue_cmd(OP_UNION, 13, 14);
        queue_cmd(OP_UNION, 14, 0);
        queue_cmd(OP_QUERY, 10, 14);                // long walk, then compressed
        queue_cmd(OP_QUERY, 10, TOP_INDEX);
        queue_cmd(OP_QUERY, 12, 2730);
        queue_cmd(OP_BAD_2, 0, 0);
        queue_cmd(OP_BAD_3, TOP_INDEX, TOP_INDEX);
        queue_cmd(OP_BAD_2, 2730, 1365);
        queue_cmd(OP_UNION, 1365, 2730);
        queue_cmd(OP_QUERY, 2730, 1365);
        queue_cmd(OP_QUERY, 1365, 13);

        // random part: no idling, sender idle 60 %, none again, then 12 %
        queue_random_phase(0);
        queue_random_phase(60);
        queue_random_phase(0);
        queue_random_phase(12);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while ((pending_cmds.size() != 0 || start || answers_due.size() != 0 || busy)
                && idle_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);

        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d items queued, %0d answers due",
                     $time, pending_cmds.size(), answers_due.size());
            $display("disjoint_set_union_find_top verification failed");
            $finish;
        end else begin
            repeat (16) @(posedge i_clk);
            if (answers_due.size() != 0) begin
                $display("%0t: %0d answers never arrived, expected %0d, actual none",
                         $time, answers_due.size(), answers_due[0]);
                fault_count++;
            end
            $display("Covered %0d unions, %0d queries, %0d invalid items; %0d answers checked",
                     n_union, n_query, n_invalid, n_checked);
            $display("(%0d same-set), across idle-free and sender-idle phases.", n_same);
            if (fault_count == 0)
                $display("disjoint_set_union_find_top verification clean");
            else
                $display("disjoint_set_union_find_top verification failed");
            $finish;
        end
    end

endmodule

>>> sim.f
design/dsu_pkg.sv
design/dsu_ram.sv
design/dsu_wrap.sv
design/disjoint_set_union_find_top.sv
test/disjoint_set_union_find_top_test.sv
